// File: src/pled_pkg.sv
// ----------------------------------------------------------------------------
// pled_pkg
// Types and constants shared by the parallel LED strip waveform driver.
// ----------------------------------------------------------------------------
package pled_pkg;

  localparam int CODE_W   = 4;
  localparam int CODES_W  = 64;
  localparam int PINS_W   = 16;
  localparam int TICK_W   = 10;
  localparam int SLOT_W   = 5;
  localparam int CFG_IDX_W = 8;
  localparam int SLOTS    = 24;

  localparam logic [CODE_W-1:0] OFF_CODE = 4'hf;

  localparam logic [TICK_W-1:0] PERIOD_RESET    = 10'd80;
  localparam logic [TICK_W-1:0] ZERO_HIGH_RESET = 10'd16;
  localparam logic [TICK_W-1:0] ONE_HIGH_RESET  = 10'd48;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH  = 8'd2;

  // frame slots that can carry a one (slot 0 is G bit 7)
  localparam logic [SLOT_W-1:0] SLOT_G1 = 5'd6;
  localparam logic [SLOT_W-1:0] SLOT_G0 = 5'd7;
  localparam logic [SLOT_W-1:0] SLOT_R1 = 5'd14;
  localparam logic [SLOT_W-1:0] SLOT_R0 = 5'd15;
  localparam logic [SLOT_W-1:0] SLOT_B0 = 5'd23;
  localparam logic [SLOT_W-1:0] LAST_SLOT = 5'(SLOTS - 1);

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TICK = 1'b1
  } opcode_t;

  typedef struct packed {
    opcode_t              opcode;
    logic [CODES_W-1:0]   lane_codes;
  } in_item_t;

  typedef struct packed {
    logic [PINS_W-1:0] pins;
    logic              pixel_done;
    logic              sending;
    logic              load_dropped;
  } out_item_t;

  // data bit of one lane for one slot of the grb frame
  function automatic logic frame_bit(input logic [CODE_W-1:0] code,
                                     input logic [SLOT_W-1:0] slot);
    logic b;
    b = 1'b0;
    if (code != OFF_CODE) begin
      case (slot)
        SLOT_G1: b = ~code[1];
        SLOT_G0: b = ~code[0];
        SLOT_R1: b = code[1];
        SLOT_R0: b = code[0];
        SLOT_B0: b = 1'b1;
        default: b = 1'b0;
      endcase
    end
    return b;
  endfunction

endpackage

// File: src/parallel_led_strip_waveform_driver_core.sv
// ----------------------------------------------------------------------------
// parallel_led_strip_waveform_driver_core
// Drives LANES one-wire LED strips in parallel, one pin word per timer tick.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : items of opcode load (lane codes start a 24-slot grb frame) or
//           tick (one timer count). Every item gives exactly one result.
//   out_* : pin word, pixel_done at the tick that ends slot 23 (the last), sending, and
//           load_dropped when a load hits a frame already in progress.
//   cfg_* : writes period_ticks (0), zero_high_ticks (1), one_high_ticks (2);
//           other indexes are ignored, cfg_ready is always high.
// The result of an item is registered and is valid after the edge that accepts
// the item. One item is taken per cycle while the output is not stalled, set by the
// single tick counter / slot counter update done at each transfer.
// The result sits in an output register; while the receiver stalls it holds,
// and in_ready drops only when that register is full and not being taken.
// Reset (synchronous, rst_n low) restores the default timing, clears the
// held codes and counters and leaves the block idle with no result pending.
// ----------------------------------------------------------------------------
module parallel_led_strip_waveform_driver_core #(
  parameter int LANES = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  pled_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output pled_pkg::out_item_t         out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [pled_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pled_pkg::TICK_W-1:0] cfg_data
);

  localparam int HELD_W = pled_pkg::CODE_W * LANES;

  logic [pled_pkg::TICK_W-1:0] period_r, zero_high_r, one_high_r;
  logic [HELD_W-1:0]           held_codes_r, held_codes_nxt;
  logic                        active_r, active_nxt;
  logic [pled_pkg::SLOT_W-1:0] slot_r, slot_nxt;
  logic [pled_pkg::TICK_W-1:0] tick_r, tick_nxt;
  logic                        out_valid_r;
  pled_pkg::out_item_t         out_r, out_nxt;

  logic                        in_xfer;
  logic [pled_pkg::PINS_W-1:0] lane_mask, data_word;
  logic                        period_end;

  assign cfg_ready = 1'b1;
  assign in_ready  = ~out_valid_r | out_ready;
  assign in_xfer   = in_valid & in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    lane_mask = '0;
    data_word = '0;
    for (int k = 0; k < LANES; k++) begin
      lane_mask[k] = 1'b1;
      data_word[k] = pled_pkg::frame_bit(
        held_codes_r[k*pled_pkg::CODE_W +: pled_pkg::CODE_W], slot_r);
    end
  end

  assign period_end = ({1'b0, tick_r} + 11'd1) >= {1'b0, period_r};

  always_comb begin
    held_codes_nxt = held_codes_r;
    active_nxt     = active_r;
    slot_nxt       = slot_r;
    tick_nxt       = tick_r;
    out_nxt        = '0;
    if (in_data.opcode == pled_pkg::OP_LOAD) begin
      out_nxt.sending = 1'b1;
      if (active_r) begin
        out_nxt.load_dropped = 1'b1;
      end else begin
        held_codes_nxt = in_data.lane_codes[HELD_W-1:0];
        active_nxt     = 1'b1;
        slot_nxt       = '0;
        tick_nxt       = '0;
      end
    end else if (active_r) begin
      out_nxt.sending = 1'b1;
      // ordered thresholds: all high, then data, then low
      if (tick_r < zero_high_r) begin
        out_nxt.pins = lane_mask;
      end else if (tick_r < one_high_r) begin
        out_nxt.pins = data_word;
      end else begin
        out_nxt.pins = '0;
      end
      if (period_end) begin
        tick_nxt = '0;
        if (slot_r >= pled_pkg::LAST_SLOT) begin
          out_nxt.pixel_done = 1'b1;
          active_nxt         = 1'b0;
          slot_nxt           = '0;
        end else begin
          slot_nxt = slot_r + 5'd1;
        end
      end else begin
        tick_nxt = tick_r + 10'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r     <= pled_pkg::PERIOD_RESET;
      zero_high_r  <= pled_pkg::ZERO_HIGH_RESET;
      one_high_r   <= pled_pkg::ONE_HIGH_RESET;
      held_codes_r <= '0;
      active_r     <= 1'b0;
      slot_r       <= '0;
      tick_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          pled_pkg::REG_PERIOD:    period_r    <= cfg_data;
          pled_pkg::REG_ZERO_HIGH: zero_high_r <= cfg_data;
          pled_pkg::REG_ONE_HIGH:  one_high_r  <= cfg_data;
          default: ;
        endcase
      end
      if (in_xfer) begin
        held_codes_r <= held_codes_nxt;
        active_r     <= active_nxt;
        slot_r       <= slot_nxt;
        tick_r       <= tick_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_r <= out_nxt;
    end
  end

`ifndef ASSERT_OFF
  // slot counter never runs past the last frame slot
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r <= pled_pkg::LAST_SLOT)
    else $error("slot index beyond frame");

  // idle means counters parked at zero
  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> (slot_r == '0 && tick_r == '0))
    else $error("counters not cleared while idle");

  // a load taken while idle starts a frame
  a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_data.opcode == pled_pkg::OP_LOAD && !active_r) |=> active_r)
    else $error("load did not start a frame");

  // flags of a pending result are consistent
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((!out_r.pixel_done || out_r.sending) &&
                     (!out_r.load_dropped || (out_r.pins == '0 && !out_r.pixel_done))))
    else $error("inconsistent result flags");
`endif

endmodule
